@@ rtl/core/dwbc_pkg.sv @@
// Package with the action codes and shared types of the word-break checker.
`timescale 1ns / 1ps
`default_nettype none
package dwbc_pkg;
	typedef enum logic [1:0] {
		ACT_DICT_BYTE = 2'd0,
		ACT_WORD_LEN  = 2'd1,
		ACT_TEXT_BYTE = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_WAIT  = 2'd2,
		ST_OUT   = 2'd3
	} state_t;
endpackage
`default_nettype wire

@@ rtl/core/dwbc_cell.sv @@
// One window cell: holds a text byte, shifts it on, and compares it against a word byte.
`timescale 1ns / 1ps
`default_nettype none
module dwbc_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       clear,
	input  wire logic       shift,
	input  wire logic [7:0] byte_in,
	input  wire logic [7:0] word_byte,
	output logic      [7:0] byte_out,
	output logic            equal
);
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end else if (clear) begin
			byte_q <= '0;
		end
	end

	assign byte_out = byte_q;
	assign equal = (byte_q == word_byte);
endmodule
`default_nettype wire

@@ rtl/core/dictionary_word_break_checker_core.sv @@
// Top level of the dictionary word-break checker.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | action word_slot char_offset byte_value
//         |           |                    | word_length first_of_text
// out     | output    | out_valid/out_ready| splittable prefix_length
//
// A text byte shifts the window at its accepting edge; the scan state then reads one entry
// per cycle from the dictionary memory into registers and compares each registered row, and
// the wait state finishes the compare of the last row and then updates the history. The
// result is held on the output until it is taken.
// The next transaction is accepted the cycle after the result is taken.
// Dictionary and length writes leave the block idle. Reset clears lengths, window, history
// and position; dictionary bytes are undefined until written.
// A waiting result holds the block until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module dictionary_word_break_checker_core #(
	parameter int NUM_WORDS    = 16,
	parameter int MAX_WORD_LEN = 16,
	parameter int POS_WIDTH    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  word_slot,
	input  wire logic [3:0]  char_offset,
	input  wire logic [7:0]  byte_value,
	input  wire logic [4:0]  word_length,
	input  wire logic        first_of_text,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             splittable,
	output logic [15:0]      prefix_length
);
	localparam int EW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int LW = $clog2(MAX_WORD_LEN + 1);
	localparam int CW = $clog2(NUM_WORDS + 1);

	dwbc_pkg::state_t state_q, state_next;

	logic [8*MAX_WORD_LEN-1:0] mem_q [NUM_WORDS];
	logic [8*MAX_WORD_LEN-1:0] row_q;
	logic [LW-1:0] len_q [NUM_WORDS];
	logic [LW-1:0] rlen_q;
	logic [MAX_WORD_LEN:0] hist_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic split_q, rvalid_q;
	logic [7:0] win [MAX_WORD_LEN+1];
	logic [MAX_WORD_LEN-1:0] eq;

	logic acc_in, is_text, shift, clear;
	assign acc_in  = in_valid && in_ready;
	assign is_text = (action == dwbc_pkg::ACT_TEXT_BYTE);
	assign shift   = acc_in && is_text;
	assign clear   = shift && first_of_text;
	assign win[0]  = byte_value;

	for (genvar g = 0; g < MAX_WORD_LEN; g++) begin : g_cell
		logic [7:0] wb;
		logic [7:0] prev;
		// Cell g holds the byte g positions back; it meets word byte len-1-g.
		always_comb begin
			wb = '0;
			for (int m = 0; m < MAX_WORD_LEN; m++) begin
				if (32'(m) == 32'(rlen_q) - 32'd1 - 32'(g)) begin
					wb = row_q[8*m +: 8];
				end
			end
		end
		assign prev = (clear && g != 0) ? 8'd0 : win[g];
		dwbc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(1'b0), .shift(shift),
			.byte_in(prev), .word_byte(wb), .byte_out(win[g+1]), .equal(eq[g])
		);
	end

	logic match;
	always_comb begin
		match = (rlen_q != '0) && hist_q[rlen_q - LW'(1)];
		for (int g = 0; g < MAX_WORD_LEN; g++) begin
			if (32'(g) < 32'(rlen_q) && !eq[g]) begin
				match = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && action == dwbc_pkg::ACT_DICT_BYTE && 32'(word_slot) < NUM_WORDS
				&& 32'(char_offset) < MAX_WORD_LEN) begin
			mem_q[EW'(word_slot)][8*OW'(char_offset) +: 8] <= byte_value;
		end
		row_q <= mem_q[EW'(cnt_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) len_q[i] <= '0;
			rlen_q   <= '0;
			hist_q   <= (MAX_WORD_LEN+1)'(1);
			pos_q    <= '0;
			cnt_q    <= '0;
			split_q  <= 1'b0;
			rvalid_q <= 1'b0;
			state_q  <= dwbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
			if (acc_in && action == dwbc_pkg::ACT_WORD_LEN && 32'(word_slot) < NUM_WORDS
					&& 32'(word_length) <= MAX_WORD_LEN) begin
				len_q[EW'(word_slot)] <= LW'(word_length);
			end
			if (shift) begin
				cnt_q   <= '0;
				split_q <= 1'b0;
				if (first_of_text) begin
					hist_q <= (MAX_WORD_LEN+1)'(1);
					pos_q  <= '0;
				end
			end
			rvalid_q <= 1'b0;
			if (state_q == dwbc_pkg::ST_SCAN) begin
				rlen_q   <= len_q[EW'(cnt_q)];
				rvalid_q <= 1'b1;
				cnt_q    <= cnt_q + CW'(1);
			end
			if (rvalid_q && match) begin
				split_q <= 1'b1;
			end
			if (state_q == dwbc_pkg::ST_WAIT && !rvalid_q) begin
				hist_q <= {hist_q[MAX_WORD_LEN-1:0], split_q};
				if (pos_q != '1) pos_q <= pos_q + POS_WIDTH'(1);
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dwbc_pkg::ST_IDLE: if (shift) state_next = dwbc_pkg::ST_SCAN;
			dwbc_pkg::ST_SCAN: if (32'(cnt_q) == NUM_WORDS - 1) state_next = dwbc_pkg::ST_WAIT;
			dwbc_pkg::ST_WAIT: if (!rvalid_q) state_next = dwbc_pkg::ST_OUT;
			dwbc_pkg::ST_OUT:  if (out_ready) state_next = dwbc_pkg::ST_IDLE;
			default:           state_next = dwbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == dwbc_pkg::ST_IDLE);
		out_valid     = (state_q == dwbc_pkg::ST_OUT);
		splittable    = hist_q[0];
		prefix_length = 16'(pos_q);
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input accepted while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("block did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> pos_q != '0)
		else $error("result with zero position");
endmodule
`default_nettype wire

@@ tb/sv/dwbc_checker.sv @@
// Checker that predicts the word-break results and compares them with the block's output.
`timescale 1ns / 1ps
`default_nettype none
module dwbc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  word_slot,
	input  wire logic [3:0]  char_offset,
	input  wire logic [7:0]  byte_value,
	input  wire logic [4:0]  word_length,
	input  wire logic        first_of_text,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        splittable,
	input  wire logic [15:0] prefix_length,
	output int               fail_count,
	output int               pending,
	output int               text_count,
	output int               split_count
);
	typedef struct packed {
		logic        split;
		logic [15:0] plen;
	} split_result_t;

	logic [7:0]    dict_bytes [16][16];
	logic [4:0]    word_lens [16];
	logic [7:0]    text_window [16];
	logic [16:0]   break_bits;
	logic [15:0]   text_pos;
	split_result_t expected_splits [$];

	task automatic restart_text();
		for (int k = 0; k < 16; k++) text_window[k] = 8'd0;
		break_bits = 17'd1;
		text_pos = 16'd0;
	endtask

	task automatic take_text_byte(input logic [7:0] b, input logic first);
		logic split;
		logic hit;
		int len;
		split = 1'b0;
		if (first) restart_text();
		for (int k = 15; k > 0; k--) text_window[k] = text_window[k - 1];
		text_window[0] = b;
		for (int e = 0; e < 16; e++) begin
			len = int'(word_lens[e]);
			if (len != 0 && len <= 16 && break_bits[len - 1]) begin
				hit = 1'b1;
				for (int m = 0; m < len; m++)
					if (dict_bytes[e][m] !== text_window[len - 1 - m]) hit = 1'b0;
				if (hit) split = 1'b1;
			end
		end
		break_bits = {break_bits[15:0], split};
		if (text_pos != 16'hffff) text_pos = text_pos + 16'd1;
		expected_splits.push_back('{split: split, plen: text_pos});
	endtask

	always @(posedge clk or negedge arst_n) begin
		split_result_t exp_res;
		if (!arst_n) begin
			for (int s = 0; s < 16; s++) word_lens[s] = 5'd0;
			restart_text();
			expected_splits.delete();
			fail_count = 0;
			text_count = 0;
			split_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_splits.size() == 0) begin
					$error("result with no transaction pending: splittable %0d length %0d",
						splittable, prefix_length);
					fail_count++;
				end else begin
					exp_res = expected_splits.pop_front();
					if (splittable !== exp_res.split) begin
						$error("splittable: expected %0d, actual %0d", exp_res.split, splittable);
						fail_count++;
					end
					if (prefix_length !== exp_res.plen) begin
						$error("prefix_length: expected %0d, actual %0d", exp_res.plen,
							prefix_length);
						fail_count++;
					end
					if (exp_res.split) split_count++;
				end
			end
			if (in_valid && in_ready) begin
				case (dwbc_pkg::action_t'(action))
					dwbc_pkg::ACT_DICT_BYTE: dict_bytes[word_slot][char_offset] = byte_value;
					dwbc_pkg::ACT_WORD_LEN: begin
						if (word_length <= 5'd16) word_lens[word_slot] = word_length;
					end
					dwbc_pkg::ACT_TEXT_BYTE: begin
						take_text_byte(byte_value, first_of_text);
						text_count++;
					end
					default: ;
				endcase
			end
			pending = expected_splits.size();
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Top of the word-break checker testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	dwbc_pkg::action_t action = dwbc_pkg::ACT_NONE;
	logic [3:0]        word_slot = 4'd0;
	logic [3:0]        char_offset = 4'd0;
	logic [7:0]        byte_value = 8'd0;
	logic [4:0]        word_length = 5'd0;
	logic              first_of_text = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              splittable;
	logic [15:0]       prefix_length;
	int                fail_count, pending, text_count, split_count;
	bit                quiet = 1'b0;
	int                idle_cycles = 0;
	int                item_count = 0;
	int                out_stall = 0;

	logic [7:0]  word_bytes [16][16];
	logic [15:0] written_mask [16];
	int          word_lens [16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dictionary_word_break_checker_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .word_slot(word_slot), .char_offset(char_offset),
		.byte_value(byte_value), .word_length(word_length), .first_of_text(first_of_text),
		.out_valid(out_valid), .out_ready(out_ready), .splittable(splittable),
		.prefix_length(prefix_length)
	);

	dwbc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .word_slot(word_slot), .char_offset(char_offset),
		.byte_value(byte_value), .word_length(word_length), .first_of_text(first_of_text),
		.out_valid(out_valid), .out_ready(out_ready), .splittable(splittable),
		.prefix_length(prefix_length), .fail_count(fail_count), .pending(pending),
		.text_count(text_count), .split_count(split_count)
	);

	always @(posedge clk) begin
		if (out_stall > 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			out_stall = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= 2000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_item(input dwbc_pkg::action_t a, input logic [3:0] s,
		input logic [3:0] o, input logic [7:0] b, input logic [4:0] l, input logic f);
		in_valid <= 1'b1;
		action <= a;
		word_slot <= s;
		char_offset <= o;
		byte_value <= b;
		word_length <= l;
		first_of_text <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (a != dwbc_pkg::ACT_NONE) item_count++;
		if (a == dwbc_pkg::ACT_DICT_BYTE) begin
			word_bytes[s][o] = b;
			written_mask[s][o] = 1'b1;
		end
		if (a == dwbc_pkg::ACT_WORD_LEN && l <= 5'd16) word_lens[s] = int'(l);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_byte(input logic [3:0] s, input logic [3:0] o, input logic [7:0] b);
		send_item(dwbc_pkg::ACT_DICT_BYTE, s, o, b, 5'($urandom), 1'($urandom));
	endtask

	task automatic set_length(input logic [3:0] s, input logic [4:0] l);
		send_item(dwbc_pkg::ACT_WORD_LEN, s, 4'($urandom), 8'($urandom), l, 1'($urandom));
	endtask

	task automatic text_byte(input logic [7:0] b, input logic f);
		send_item(dwbc_pkg::ACT_TEXT_BYTE, 4'($urandom), 4'($urandom), b, 5'($urandom), f);
	endtask

	function automatic int usable_length(input int s, input int want);
		int l;
		l = 0;
		while (l < want && written_mask[s][l]) l++;
		return l;
	endfunction

	task automatic build_word();
		int s, len;
		s = $urandom_range(0, 15);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
		for (int m = 0; m < len; m++)
			write_byte(4'(s), 4'(m), 8'(8'h61 + $urandom_range(0, 2)));
		set_length(4'(s), 5'(len));
	endtask

	task automatic send_sentence();
		int n, s, tries;
		bit first;
		first = 1'b1;
		n = $urandom_range(1, 4);
		for (int w = 0; w < n; w++) begin
			s = $urandom_range(0, 15);
			tries = 0;
			while (word_lens[s] == 0 && tries < 16) begin
				s = (s + 1) % 16;
				tries++;
			end
			if (word_lens[s] == 0) begin
				text_byte(8'h61, first);
				first = 1'b0;
			end else begin
				for (int m = 0; m < word_lens[s]; m++) begin
					if ($urandom_range(0, 24) == 0) text_byte(8'($urandom), first);
					else text_byte(word_bytes[s][m], first);
					first = 1'b0;
				end
			end
		end
	endtask

	task automatic send_noise();
		int s;
		case ($urandom_range(0, 5))
			0: send_item(dwbc_pkg::ACT_NONE, 4'($urandom), 4'($urandom), 8'($urandom),
				5'($urandom), 1'($urandom));
			1: set_length(4'($urandom), 5'($urandom_range(17, 31)));
			2: begin
				s = $urandom_range(0, 15);
				set_length(4'(s), 5'(usable_length(s, $urandom_range(0, 16))));
			end
			3: write_byte(4'($urandom), 4'($urandom), 8'($urandom));
			default: text_byte(($urandom_range(0, 3) == 0) ? 8'($urandom)
				: 8'(8'h61 + $urandom_range(0, 2)), 1'($urandom_range(0, 5) == 0));
		endcase
	endtask

	initial begin
		for (int s = 0; s < 16; s++) begin
			written_mask[s] = 16'd0;
			word_lens[s] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		text_byte(8'h61, 1'b0);
		write_byte(4'd0, 4'd0, 8'h61);
		write_byte(4'd0, 4'd1, 8'h62);
		set_length(4'd0, 5'd2);
		write_byte(4'd1, 4'd0, 8'h61);
		set_length(4'd1, 5'd1);
		write_byte(4'd2, 4'd0, 8'h61);
		set_length(4'd2, 5'd1);
		set_length(4'd1, 5'd17);
		set_length(4'd1, 5'd31);
		send_item(dwbc_pkg::ACT_NONE, 4'hf, 4'hf, 8'hff, 5'h1f, 1'b1);
		write_byte(4'd15, 4'd15, 8'hff);
		write_byte(4'd15, 4'd0, 8'h00);
		text_byte(8'h61, 1'b1);
		text_byte(8'h62, 1'b0);
		text_byte(8'h61, 1'b0);
		text_byte(8'h61, 1'b0);
		text_byte(8'h63, 1'b0);
		text_byte(8'hff, 1'b0);
		set_length(4'd2, 5'd0);
		text_byte(8'h61, 1'b1);
		text_byte(8'h00, 1'b1);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		while (item_count < 820) begin
			if (item_count > 700) quiet = 1'b1;
			case ($urandom_range(0, 9))
				0, 1: build_word();
				2, 3: send_noise();
				default: send_sentence();
			endcase
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d transactions, %0d text bytes, %0d splittable prefixes.",
			item_count, text_count, split_count);
		$display("Dictionary writes, length updates, overlong and unknown actions included.");
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ dictionary_word_break_checker_core.f @@
rtl/core/dwbc_pkg.sv
rtl/core/dwbc_cell.sv
rtl/core/dictionary_word_break_checker_core.sv
tb/sv/dwbc_checker.sv
tb/sv/testbench.sv
